// File: src/lmss_pkg.sv
// lmss_pkg: shared types, constants and address helpers for the led matrix scan/scroll block
// no dependencies; used by every file in src but lmss_ram

`default_nettype none

package lmss_pkg;

    // default frame store depth and the longest scroll ring
    localparam int FRAME_DEPTH_DEF = 64;
    localparam int RING_MAX        = 64;
    localparam int SHOWN_COLUMNS   = 8;
    localparam int LEN_W           = 7;
    localparam int POS_W           = 6;
    localparam int COL_W           = 3;

    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_START  = 2'd1,
        CMD_TICK   = 2'd2,
        CMD_SCROLL = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t             command;
        logic [POS_W-1:0] position;
        logic [7:0]       data;
    } cmd_word_t;

    typedef struct packed {
        logic [7:0] column_enable_n;
        logic [7:0] row_bits;
    } pins_word_t;

    // status of the rotation base unit
    typedef struct packed {
        logic             busy;
        logic [POS_W-1:0] base;
    } base_stat_t;

    // frame length clamped to [8, cap]
    function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len,
                                                 input logic [LEN_W-1:0] cap);
        logic [LEN_W-1:0] r;
        r = len;
        if (r < LEN_W'(SHOWN_COLUMNS))
            r = LEN_W'(SHOWN_COLUMNS);
        if (r > cap)
            r = cap;
        return r;
    endfunction

    // logical position to physical slot; base is already below len
    function automatic logic [LEN_W-1:0] slot_of(input logic [POS_W-1:0] pos,
                                                 input logic [POS_W-1:0] base,
                                                 input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] s;
        s = {1'b0, pos};
        if ({1'b0, pos} < len)
        begin
            s = {1'b0, base} + {1'b0, pos};
            if (s >= len)
                s = s - len;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// File: src/lmss_ram.sv
// lmss_ram: generic single-port RAM with registered read
// no dependencies

`default_nettype none

module lmss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [WIDTH-1:0]  wdata,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[addr] <= wdata;
        if (re)
            rdata <= mem_reg[addr];
    end

endmodule

`default_nettype wire

// File: src/lmss_base.sv
// lmss_base: scroll rotation base, kept raw and reduced modulo the ring length
// depends on lmss_pkg

`default_nettype none

module lmss_base (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write_en,
    input  wire logic                          rotate,
    input  wire logic [lmss_pkg::LEN_W-1:0]    len,
    output lmss_pkg::base_stat_t               stat
);

    logic [lmss_pkg::POS_W-1:0] raw_reg, raw_next;
    logic [lmss_pkg::POS_W-1:0] red_reg, red_next;
    logic [lmss_pkg::LEN_W-1:0] inc;
    logic [lmss_pkg::LEN_W-1:0] diff;
    logic                       busy;

    // reduction runs one subtract per cycle after a length change
    assign busy = {1'b0, red_reg} >= len;
    assign inc  = {1'b0, red_reg} + lmss_pkg::LEN_W'(1);
    assign diff = {1'b0, red_reg} - len;

    always_comb
    begin
        raw_next = raw_reg;
        red_next = red_reg;
        priority if (cfg_write_en)
        begin
            red_next = raw_reg;
        end
        else if (busy)
        begin
            red_next = diff[lmss_pkg::POS_W-1:0];
        end
        else if (rotate)
        begin
            red_next = (inc == len) ? '0 : inc[lmss_pkg::POS_W-1:0];
            raw_next = red_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_reg <= '0;
            red_reg <= '0;
        end
        else
        begin
            raw_reg <= raw_next;
            red_reg <= red_next;
        end
    end

    assign stat.busy = busy;
    assign stat.base = red_reg;

endmodule

`default_nettype wire

// File: src/led_matrix_scan_scroll_core.sv
// led_matrix_scan_scroll_core: 8x8 led matrix column scan with a scrollable frame store
// path: an accepted command is registered in stage 1, then in the pin registers, which hold while pins_ready is low
// throughput: one command per cycle while the pin word channel does not stall; after a cfg write,
//   cmd_ready drops while the rotation base is reduced by one subtract per cycle
// reset: async active low; frame reads as zero (per-entry valid bits), columns all off,
//   rows zero, scan column and rotation base zero, frame length 8
// depends on lmss_pkg, lmss_base, lmss_ram

`default_nettype none

module led_matrix_scan_scroll_core #(
    parameter int FRAME_DEPTH = lmss_pkg::FRAME_DEPTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // command channel
    input  wire logic                           cmd_valid,
    output logic                                cmd_ready,
    input  wire lmss_pkg::cmd_word_t            cmd_word,
    // pin word channel
    output logic                                pins_valid,
    input  wire logic                           pins_ready,
    output lmss_pkg::pins_word_t                pins_word,
    // frame length register
    input  wire logic                           cfg_write_en,
    input  wire logic [lmss_pkg::LEN_W-1:0]     cfg_write_data
);

    localparam int ADDR_W  = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
    localparam int LEN_CAP = (FRAME_DEPTH < lmss_pkg::RING_MAX) ? FRAME_DEPTH
                                                                 : lmss_pkg::RING_MAX;

    // frame length register
    logic [lmss_pkg::LEN_W-1:0] frame_length_reg, frame_length_next;
    logic [lmss_pkg::LEN_W-1:0] len;

    // scan column and the per-entry written flags of the frame store
    logic [lmss_pkg::COL_W-1:0] scan_col_reg, scan_col_next;
    logic [FRAME_DEPTH-1:0]     written_reg, written_next;

    // stage 1: store access in flight
    logic                       s1_valid_reg, s1_valid_next;
    logic                       s1_show_reg, s1_show_next;
    logic [lmss_pkg::COL_W-1:0] s1_col_reg, s1_col_next;
    logic                       s1_hit_reg, s1_hit_next;

    // stage 2: pin registers, which are also the output word
    logic                       pins_valid_reg, pins_valid_next;
    logic [7:0]                 col_pins_reg, col_pins_next;
    logic [7:0]                 row_pins_reg, row_pins_next;

    logic                       accept;
    logic                       out_free;
    logic                       s1_move;
    logic                       is_write;
    logic                       is_show;
    logic                       is_scroll;
    logic [lmss_pkg::COL_W-1:0] col_sel;
    logic [lmss_pkg::POS_W-1:0] pos_sel;
    logic [lmss_pkg::LEN_W-1:0] slot;
    logic                       slot_ok;
    logic [ADDR_W-1:0]          ram_addr;
    logic                       ram_we;
    logic                       ram_re;
    logic [7:0]                 ram_rdata;
    lmss_pkg::base_stat_t       base_stat;

    // handshake: a new command enters when stage 1 is empty or empties this cycle and the base is not busy
    assign accept    = cmd_valid && cmd_ready;
    assign out_free  = !pins_valid_reg || pins_ready;
    assign s1_move   = s1_valid_reg && out_free;
    assign cmd_ready = !base_stat.busy && (!s1_valid_reg || out_free);

    assign len = lmss_pkg::eff_len(frame_length_reg, lmss_pkg::LEN_W'(LEN_CAP));

    // command decode and next scan column
    always_comb
    begin
        is_write  = 1'b0;
        is_show   = 1'b0;
        is_scroll = 1'b0;
        col_sel   = scan_col_reg;
        unique case (cmd_word.command)
            lmss_pkg::CMD_WRITE:
            begin
                is_write = 1'b1;
            end
            lmss_pkg::CMD_START:
            begin
                is_show = 1'b1;
                col_sel = '0;
            end
            lmss_pkg::CMD_TICK:
            begin
                is_show = 1'b1;
                col_sel = scan_col_reg + lmss_pkg::COL_W'(1);
            end
            lmss_pkg::CMD_SCROLL:
            begin
                is_scroll = 1'b1;
            end
            default:
            begin
                is_write = 1'b0;
            end
        endcase
    end

    // a shown column always sits inside the ring; writes may land past it
    assign pos_sel  = is_show ? {{(lmss_pkg::POS_W-lmss_pkg::COL_W){1'b0}}, col_sel}
                              : cmd_word.position;
    assign slot     = lmss_pkg::slot_of(pos_sel, base_stat.base, len);
    assign slot_ok  = 32'(slot) < 32'(FRAME_DEPTH);
    assign ram_addr = ADDR_W'(slot);
    assign ram_we   = accept && is_write && slot_ok;
    assign ram_re   = accept && is_show;

    lmss_base u_base (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .rotate       (accept && is_scroll),
        .len          (len),
        .stat         (base_stat)
    );

    lmss_ram #(
        .WIDTH  (8),
        .DEPTH  (FRAME_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_frame (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (cmd_word.data),
        .rdata (ram_rdata)
    );

    // state updated at accept; the frame length at a cfg write
    always_comb
    begin
        frame_length_next = cfg_write_en ? cfg_write_data : frame_length_reg;
        scan_col_next     = scan_col_reg;
        written_next      = written_reg;
        if (accept && is_show)
            scan_col_next = col_sel;
        if (ram_we)
            written_next[ram_addr] = 1'b1;
    end

    // stage 1 capture
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_show_next  = s1_show_reg;
        s1_col_next   = s1_col_reg;
        s1_hit_next   = s1_hit_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
            s1_show_next  = is_show;
            s1_col_next   = col_sel;
            s1_hit_next   = written_reg[ram_addr];
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // pin update: never-written entries read as zero
    always_comb
    begin
        pins_valid_next = pins_valid_reg;
        col_pins_next   = col_pins_reg;
        row_pins_next   = row_pins_reg;
        if (s1_move)
        begin
            pins_valid_next = 1'b1;
            if (s1_show_reg)
            begin
                col_pins_next = ~(8'b1 << s1_col_reg);
                row_pins_next = s1_hit_reg ? ram_rdata : 8'h00;
            end
        end
        else if (pins_ready)
        begin
            pins_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_length_reg <= lmss_pkg::LEN_W'(lmss_pkg::SHOWN_COLUMNS);
            scan_col_reg     <= '0;
            written_reg      <= '0;
            s1_valid_reg     <= 1'b0;
            pins_valid_reg   <= 1'b0;
            col_pins_reg     <= 8'hFF;
            row_pins_reg     <= 8'h00;
        end
        else
        begin
            frame_length_reg <= frame_length_next;
            scan_col_reg     <= scan_col_next;
            written_reg      <= written_next;
            s1_valid_reg     <= s1_valid_next;
            pins_valid_reg   <= pins_valid_next;
            col_pins_reg     <= col_pins_next;
            row_pins_reg     <= row_pins_next;
        end
    end

    // stage 1 payload
    always_ff @(posedge clk)
    begin
        s1_show_reg <= s1_show_next;
        s1_col_reg  <= s1_col_next;
        s1_hit_reg  <= s1_hit_next;
    end

    assign pins_valid                = pins_valid_reg;
    assign pins_word.column_enable_n = col_pins_reg;
    assign pins_word.row_bits        = row_pins_reg;

endmodule

`default_nettype wire

// File: src/lmss_checker.sv
// lmss_checker: port-level assertions for led_matrix_scan_scroll_core, bound to the top level
// depends on lmss_pkg and led_matrix_scan_scroll_core

`default_nettype none

module lmss_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       cmd_valid,
    input wire logic                       cmd_ready,
    input wire logic                       pins_valid,
    input wire logic                       pins_ready,
    input wire lmss_pkg::pins_word_t       pins_word,
    input wire logic                       cfg_write_en
);

    // column drive is all off or exactly one column low
    a_col_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        pins_valid |-> ($onehot(~pins_word.column_enable_n)
                        || pins_word.column_enable_n == 8'hFF))
        else $error("column drive not one-hot low");

    // rows stay dark until a column has been shown
    a_dark_rows: assert property (@(posedge clk) disable iff (!rst_n)
        (pins_valid && pins_word.column_enable_n == 8'hFF) |-> pins_word.row_bits == 8'h00)
        else $error("row bits driven with all columns off");

    // length written only with the block idle and ready for the next command
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write_en |-> (!cmd_valid && cmd_ready && !pins_valid))
        else $error("length written with words in flight");

    // stalled pin word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (pins_valid && !pins_ready) |=> (pins_valid && $stable(pins_word)))
        else $error("pin word changed while stalled");

    // once shown, a column drive never returns to all off
    a_col_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (pins_valid && pins_word.column_enable_n != 8'hFF)
            |=> pins_word.column_enable_n != 8'hFF)
        else $error("column drive returned to all off");

endmodule

bind led_matrix_scan_scroll_core lmss_checker u_lmss_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (cmd_valid),
    .cmd_ready      (cmd_ready),
    .pins_valid     (pins_valid),
    .pins_ready     (pins_ready),
    .pins_word      (pins_word),
    .cfg_write_en   (cfg_write_en)
);

`default_nettype wire

// File: tb/sv/led_matrix_scan_scroll_core_tb.sv
// led_matrix_scan_scroll_core_tb: self-checking bench for the led matrix scan/scroll core
// drives command words, mirrors frame store, scroll base and pin registers, checks pin words
// depends on lmss_pkg and led_matrix_scan_scroll_core

module led_matrix_scan_scroll_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import lmss_pkg::*;

    localparam int DEPTH      = FRAME_DEPTH_DEF;
    localparam int RING_CAP   = (DEPTH < RING_MAX) ? DEPTH : RING_MAX;
    localparam int HOLD_LONG  = 64;
    localparam int TAIL_WAIT  = 12;

    // clock, reset and dut ports
    logic                 clk;
    logic                 rst_n;
    logic                 cmd_valid;
    logic                 cmd_ready;
    cmd_word_t            cmd_word;
    logic                 pins_valid;
    logic                 pins_ready;
    pins_word_t           pins_word;
    logic                 cfg_write_en;
    logic [LEN_W-1:0]     cfg_write_data;

    // idling controls shared by the stimulus and the pin word receiver
    bit                   src_gaps_on;
    bit                   sink_gaps_on;
    bit                   hold_req;
    int                   error_count;

    // mirror of the block state
    logic [7:0]           frame_mirror [0:DEPTH-1];
    int unsigned          rot_base;
    int unsigned          scan_col;
    logic [7:0]           col_pins;
    logic [7:0]           row_pins;
    logic [LEN_W-1:0]     frame_len;

    // pin words predicted but not yet seen at the output
    pins_word_t           pending_pins [$];

    led_matrix_scan_scroll_core #(
        .FRAME_DEPTH    (DEPTH)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd_ready      (cmd_ready),
        .cmd_word       (cmd_word),
        .pins_valid     (pins_valid),
        .pins_ready     (pins_ready),
        .pins_word      (pins_word),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #2 clk = ~clk;
    end

    // watchdog: far beyond the slowest legal run
    initial
    begin
        #400000;
        $display("led_matrix_scan_scroll_core_tb failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // frame mirror
    // ------------------------------------------------------------------

    // frame length clamped to the legal ring size
    function automatic int unsigned ring_length();
        int unsigned len;
        len = frame_len;
        if (len < SHOWN_COLUMNS)
            len = SHOWN_COLUMNS;
        if (len > RING_CAP)
            len = RING_CAP;
        return len;
    endfunction

    // positions inside the ring are offset by the scroll base, the rest map straight
    function automatic int unsigned phys_slot(int unsigned pos);
        int unsigned len;
        len = ring_length();
        if (pos < len)
            return (rot_base + pos) % len;
        return pos;
    endfunction

    // load the pin registers from the current scan column
    function automatic void show_column();
        int unsigned s;
        scan_col = scan_col % SHOWN_COLUMNS;
        s = phys_slot(scan_col);
        col_pins = ~(8'd1 << scan_col);
        row_pins = (s < DEPTH) ? frame_mirror[s] : 8'd0;
    endfunction

    function automatic void clear_mirror();
        foreach (frame_mirror[i])
            frame_mirror[i] = 8'd0;
        rot_base  = 0;
        scan_col  = 0;
        col_pins  = 8'hFF;
        row_pins  = 8'd0;
        frame_len = LEN_W'(SHOWN_COLUMNS);
    endfunction

    // apply one accepted command word and queue the pin word it produces
    function automatic void predict_pins(cmd_word_t w);
        int unsigned s;
        pins_word_t  p;
        case (w.command)
            CMD_WRITE:
            begin
                s = phys_slot(w.position);
                if (s < DEPTH)
                    frame_mirror[s] = w.data;
            end
            CMD_START:
            begin
                scan_col = 0;
                show_column();
            end
            CMD_TICK:
            begin
                scan_col = (scan_col + 1) % SHOWN_COLUMNS;
                show_column();
            end
            default:
                rot_base = (rot_base + 1) % ring_length();
        endcase
        // write and scroll leave the pins as they were
        p.column_enable_n = col_pins;
        p.row_bits        = row_pins;
        pending_pins.push_back(p);
    endfunction

    function automatic void check_pins(pins_word_t got);
        pins_word_t want;
        if (pending_pins.size() == 0)
        begin
            $display("%0t: unexpected pin word %h", $time, got);
            error_count++;
            return;
        end
        want = pending_pins.pop_front();
        if (got.column_enable_n !== want.column_enable_n)
        begin
            $display("%0t: column_enable_n expected %h actual %h",
                     $time, want.column_enable_n, got.column_enable_n);
            error_count++;
        end
        if (got.row_bits !== want.row_bits)
        begin
            $display("%0t: row_bits expected %h actual %h",
                     $time, want.row_bits, got.row_bits);
            error_count++;
        end
    endfunction

    // sample both handshakes at the rising edge; predict before checking so the
    // queue order never depends on process order
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_valid && cmd_ready)
                predict_pins(cmd_word);
            if (pins_valid && pins_ready)
                check_pins(pins_word);
        end
    end

    // ------------------------------------------------------------------
    // pin word receiver: random stall bursts, plus one long hold on request
    // ------------------------------------------------------------------
    initial
    begin
        pins_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                pins_ready <= 1'b0;
                repeat (HOLD_LONG - 1)
                    @(negedge clk);
                hold_req = 1'b0;
            end
            else if (sink_gaps_on && $urandom_range(0, 5) == 0)
            begin
                pins_ready <= 1'b0;
                repeat ($urandom_range(1, 5) - 1)
                    @(negedge clk);
            end
            else
                pins_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers; every task starts and ends at a falling edge
    // ------------------------------------------------------------------

    function automatic cmd_word_t make_cmd(cmd_t c, logic [POS_W-1:0] pos, logic [7:0] d);
        cmd_word_t w;
        w.command  = c;
        w.position = pos;
        w.data     = d;
        return w;
    endfunction

    // mostly writes and ticks, with enough scrolls to walk the base around the ring
    function automatic cmd_word_t random_cmd();
        int unsigned      r;
        logic [POS_W-1:0] pos;
        cmd_t             c;
        r   = $urandom_range(0, 9);
        pos = $urandom_range(0, 1) ? POS_W'($urandom_range(0, 7))
                                   : POS_W'($urandom_range(0, 63));
        if (r < 4)
            c = CMD_WRITE;
        else if (r == 4)
            c = CMD_START;
        else if (r < 8)
            c = CMD_TICK;
        else
            c = CMD_SCROLL;
        return make_cmd(c, pos, 8'($urandom));
    endfunction

    // offer one word and hold it until taken
    task automatic send_cmd(cmd_word_t w);
        if (src_gaps_on && $urandom_range(0, 3) == 0)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 5))
                @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_word  <= w;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_results_drained();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending_pins.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // frame length changes only with the block idle
    task automatic write_frame_length(logic [LEN_W-1:0] len);
        wait_results_drained();
        repeat (4)
            @(negedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= len;
        frame_len       = len;
        @(negedge clk);
        cfg_write_en   <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // tick straight out of reset advances from column 0 over an empty frame
    task automatic test_tick_before_start();
        repeat (2)
            send_cmd(make_cmd(CMD_TICK, '0, '0));
    endtask

    // fill the shown columns with edge patterns, then scan a full lap and wrap
    task automatic test_frame_and_scan();
        logic [7:0] patterns [0:7];
        patterns = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'hAA, 8'h55, 8'h0F, 8'hF0};
        for (int i = 0; i < 8; i++)
            send_cmd(make_cmd(CMD_WRITE, POS_W'(i), patterns[i]));
        // outside the ring: stored unrotated, never shown
        send_cmd(make_cmd(CMD_WRITE, POS_W'(63), 8'hFF));
        send_cmd(make_cmd(CMD_START, POS_W'(63), 8'hFF));
        repeat (8)
            send_cmd(make_cmd(CMD_TICK, '0, '0));
    endtask

    // scroll leaves the pins alone until the next tick or start
    task automatic test_scroll_ring();
        send_cmd(make_cmd(CMD_SCROLL, '0, '0));
        send_cmd(make_cmd(CMD_WRITE, POS_W'(1), 8'h3C));
        send_cmd(make_cmd(CMD_TICK, '0, '0));
        send_cmd(make_cmd(CMD_START, '0, '0));
    endtask

    // lengths below and above the legal range clamp, base kept across changes
    task automatic test_length_extremes();
        write_frame_length(LEN_W'(0));
        send_cmd(make_cmd(CMD_SCROLL, '0, '0));
        send_cmd(make_cmd(CMD_START, '0, '0));
        write_frame_length(LEN_W'(127));
        send_cmd(make_cmd(CMD_WRITE, POS_W'(63), 8'h5A));
        send_cmd(make_cmd(CMD_SCROLL, '0, '0));
        send_cmd(make_cmd(CMD_TICK, '0, '0));
    endtask

    task automatic test_random_traffic(logic [LEN_W-1:0] len, int count);
        write_frame_length(len);
        repeat (count)
            send_cmd(random_cmd());
    endtask

    // output held off while words keep coming, so the core backs up and stalls
    task automatic test_stall_backpressure();
        wait_results_drained();
        hold_req = 1'b1;
        repeat (60)
            send_cmd(random_cmd());
        // pause until the backlog is fully out
        wait_results_drained();
    endtask

    // full rate on both sides to finish
    task automatic test_quiet_tail();
        src_gaps_on  = 1'b0;
        sink_gaps_on = 1'b0;
        test_random_traffic(LEN_W'($urandom_range(9, 63)), 110);
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n          = 1'b0;
        cmd_valid      = 1'b0;
        cmd_word       = '0;
        cfg_write_en   = 1'b0;
        cfg_write_data = '0;
        src_gaps_on    = 1'b1;
        sink_gaps_on   = 1'b1;
        hold_req       = 1'b0;
        error_count    = 0;
        clear_mirror();

        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2)
            @(negedge clk);

        test_tick_before_start();
        test_frame_and_scan();
        test_scroll_ring();
        test_length_extremes();

        // long ring first so the base grows past the short ring that follows
        test_random_traffic(LEN_W'(64), 140);
        test_random_traffic(LEN_W'(8), 140);
        test_random_traffic(LEN_W'(0), 100);
        test_random_traffic(LEN_W'(127), 100);
        test_random_traffic(LEN_W'($urandom_range(9, 63)), 140);
        test_stall_backpressure();
        test_random_traffic(LEN_W'(65), 80);
        test_random_traffic(LEN_W'($urandom_range(0, 127)), 80);
        test_quiet_tail();

        wait_results_drained();
        // catch any stray word after the last expected one
        repeat (TAIL_WAIT)
            @(posedge clk);

        if (error_count == 0 && pending_pins.size() == 0)
            $display("led_matrix_scan_scroll_core_tb passed");
        else
            $display("led_matrix_scan_scroll_core_tb failed");
        $finish;
    end

endmodule
